// File: rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and opcodes for the complex arithmetic unit
// Opcode codes and the per-beat control word carried down the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_ADD_REAL = 4'd4,
      OP_SUB_REAL = 4'd5,
      OP_MUL_REAL = 4'd6,
      OP_DIV_REAL = 4'd7,
      OP_CONJ     = 4'd8
   } opcode_type;

   typedef struct packed {
      logic valid;
      logic is_div;
      logic dz;
      logic eq;
   } ctl_type;

endpackage

// File: rtl/core/cau_divider.sv
// ----------------------------------------------------------------------------
// cau_divider: pipelined signed divider
// One quotient bit per stage, truncating toward zero; a beat may enter
// every cycle. Control bits ride along with the data.
// ----------------------------------------------------------------------------
module cau_divider #(
   parameter int W = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [W-1:0]    in_num,
   input  logic signed [W-1:0]    in_den,
   input  cau_pkg::ctl_type       in_ctl,
   input  logic        [W-1:0]    in_pass_real,
   input  logic        [W-1:0]    in_pass_imag,
   output logic                   out_valid,
   output logic        [W-1:0]    out_quot,
   output cau_pkg::ctl_type       out_ctl,
   output logic        [W-1:0]    out_pass_real,
   output logic        [W-1:0]    out_pass_imag
);
   import cau_pkg::*;

   logic [W:0]   vld_ff;
   logic [W-1:0] rem_ff  [W+1];
   logic [W-1:0] quo_ff  [W+1];
   logic [W-1:0] den_ff  [W+1];
   logic         neg_ff  [W+1];
   ctl_type      ctl_ff  [W+1];
   logic [W-1:0] pr_ff   [W+1];
   logic [W-1:0] pi_ff   [W+1];

   logic [W-1:0] num_mag_in, den_mag_in;

   always_comb begin
      num_mag_in = in_num[W-1] ? W'(-in_num) : W'(in_num);
      den_mag_in = in_den[W-1] ? W'(-in_den) : W'(in_den);
   end

   // stage 0 registers magnitudes; stages 1..W each resolve one quotient bit
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      quo_ff[0] <= num_mag_in;
      den_ff[0] <= den_mag_in;
      neg_ff[0] <= in_num[W-1] ^ in_den[W-1];
      ctl_ff[0] <= in_ctl;
      pr_ff[0]  <= in_pass_real;
      pi_ff[0]  <= in_pass_imag;
   end

   for (genvar s = 0; s < W; s++) begin : g_stage
      logic [W:0]   trial;
      logic [W:0]   diff;
      always_comb begin
         trial = {rem_ff[s], quo_ff[s][W-1]};
         diff  = trial - {1'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (!diff[W]) begin
            rem_ff[s+1] <= diff[W-1:0];
         end else begin
            rem_ff[s+1] <= trial[W-1:0];
         end
         quo_ff[s+1] <= {quo_ff[s][W-2:0], ~diff[W]};
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         ctl_ff[s+1] <= ctl_ff[s];
         pr_ff[s+1]  <= pr_ff[s];
         pi_ff[s+1]  <= pi_ff[s];
      end
   end

   assign out_valid     = vld_ff[W];
   assign out_quot      = neg_ff[W] ? W'(-quo_ff[W]) : quo_ff[W];
   assign out_ctl       = ctl_ff[W];
   assign out_pass_real = pr_ff[W];
   assign out_pass_imag = pi_ff[W];

endmodule

// File: rtl/core/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: complex ALU with add/sub/mul/div, scalar and conj
// Every opcode takes the same path to rsp_valid: operand register, combine
// register, the bit-per-stage divider, output register. Throughput: one beat
// per cycle; busy is held low. Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic        [3:0]            req_opcode,
   input  logic signed [DATA_WIDTH-1:0] req_a_real,
   input  logic signed [DATA_WIDTH-1:0] req_a_imag,
   input  logic signed [DATA_WIDTH-1:0] req_b_real,
   input  logic signed [DATA_WIDTH-1:0] req_b_imag,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_res_real,
   output logic signed [DATA_WIDTH-1:0] rsp_res_imag,
   output logic                         rsp_operands_equal,
   output logic                         rsp_divide_by_zero
);
   import cau_pkg::*;
   localparam int W = DATA_WIDTH;

   // stage 1: register operands, plain products
   logic              s1_v_ff;
   opcode_type        s1_op_ff;
   logic [W-1:0]      s1_ar_ff, s1_ai_ff, s1_br_ff, s1_bi_ff;
   logic [W-1:0]      p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic              s1_eq_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff <= opcode_type'(req_opcode);
      s1_ar_ff <= req_a_real;
      s1_ai_ff <= req_a_imag;
      s1_br_ff <= req_b_real;
      s1_bi_ff <= req_b_imag;
      s1_eq_ff <= (req_a_real == req_b_real) && (req_a_imag == req_b_imag);
      p_rr_ff  <= W'(req_a_real * req_b_real);
      p_ii_ff  <= W'(req_a_imag * req_b_imag);
      p_ri_ff  <= W'(req_a_real * req_b_imag);
      p_ir_ff  <= W'(req_a_imag * req_b_real);
      p_bb_ff  <= W'(req_b_real * req_b_real);
      p_cc_ff  <= W'(req_b_imag * req_b_imag);
   end

   // stage 2: combine terms, pick result or dividend pair
   logic          s2_v_ff;
   ctl_type       s2_ctl_ff;
   logic [W-1:0]  s2_nr_ff, s2_ni_ff, s2_den_ff;
   ctl_type       ctl_in;
   logic [W-1:0]  nr_in, ni_in, den_in;

   always_comb begin
      ctl_in.valid  = s1_v_ff;
      ctl_in.is_div = 1'b0;
      ctl_in.dz     = 1'b0;
      ctl_in.eq     = s1_eq_ff;
      nr_in  = '0;
      ni_in  = '0;
      den_in = W'(1);
      case (s1_op_ff)
         OP_ADD: begin
            nr_in = s1_ar_ff + s1_br_ff;
            ni_in = s1_ai_ff + s1_bi_ff;
         end
         OP_SUB: begin
            nr_in = s1_ar_ff - s1_br_ff;
            ni_in = s1_ai_ff - s1_bi_ff;
         end
         OP_MUL: begin
            nr_in = p_rr_ff - p_ii_ff;
            ni_in = p_ri_ff + p_ir_ff;
         end
         OP_DIV: begin
            nr_in = p_rr_ff + p_ii_ff;
            ni_in = p_ir_ff - p_ri_ff;
            den_in = p_bb_ff + p_cc_ff;
            ctl_in.is_div = 1'b1;
         end
         OP_ADD_REAL: begin
            nr_in = s1_ar_ff + s1_br_ff;
            ni_in = s1_ai_ff;
         end
         OP_SUB_REAL: begin
            nr_in = s1_ar_ff - s1_br_ff;
            ni_in = s1_ai_ff;
         end
         OP_MUL_REAL: begin
            nr_in = p_rr_ff;
            ni_in = p_ir_ff;
         end
         OP_DIV_REAL: begin
            nr_in = s1_ar_ff;
            ni_in = s1_ai_ff;
            den_in = s1_br_ff;
            ctl_in.is_div = 1'b1;
         end
         OP_CONJ: begin
            nr_in = s1_ar_ff;
            ni_in = W'(-s1_ai_ff);
         end
         default: begin
            nr_in = '0;
            ni_in = '0;
         end
      endcase
      if (ctl_in.is_div && den_in == '0) begin
         ctl_in.dz = 1'b1;
         den_in    = W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_ctl_ff <= ctl_in;
      s2_nr_ff  <= nr_in;
      s2_ni_ff  <= ni_in;
      s2_den_ff <= den_in;
   end

   // divider lanes; non-divide beats pass their result alongside
   logic          dr_v, di_v;
   logic [W-1:0]  qr, qi, pass_r, pass_i, unused_r, unused_i;
   ctl_type       dctl, unused_ctl;

   cau_divider #(.W(W)) u_div_real (
      .clock(clock), .reset(reset), .in_valid(s2_v_ff),
      .in_num(s2_nr_ff), .in_den(s2_den_ff), .in_ctl(s2_ctl_ff),
      .in_pass_real(s2_nr_ff), .in_pass_imag(s2_ni_ff),
      .out_valid(dr_v), .out_quot(qr), .out_ctl(dctl),
      .out_pass_real(pass_r), .out_pass_imag(pass_i)
   );

   cau_divider #(.W(W)) u_div_imag (
      .clock(clock), .reset(reset), .in_valid(s2_v_ff),
      .in_num(s2_ni_ff), .in_den(s2_den_ff), .in_ctl(s2_ctl_ff),
      .in_pass_real(s2_nr_ff), .in_pass_imag(s2_ni_ff),
      .out_valid(di_v), .out_quot(qi), .out_ctl(unused_ctl),
      .out_pass_real(unused_r), .out_pass_imag(unused_i)
   );

   // output register
   logic          rsp_v_ff;
   logic [W-1:0]  rr_ff, ri_ff;
   logic          eq_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= dr_v;
      end
   end

   always_ff @(posedge clock) begin
      eq_ff <= dctl.eq;
      dz_ff <= dctl.dz;
      if (dctl.dz) begin
         rr_ff <= '0;
         ri_ff <= '0;
      end else if (dctl.is_div) begin
         rr_ff <= qr;
         ri_ff <= qi;
      end else begin
         rr_ff <= pass_r;
         ri_ff <= pass_i;
      end
   end

   assign rsp_valid          = rsp_v_ff;
   assign rsp_res_real       = rr_ff;
   assign rsp_res_imag       = ri_ff;
   assign rsp_operands_equal = eq_ff;
   assign rsp_divide_by_zero = dz_ff;

   // lanes must stay in lockstep with each other and with the control word
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      dr_v == di_v) else $error("divider lanes out of step");
   a_ctl_valid: assert property (@(posedge clock) disable iff (reset)
      dr_v |-> dctl.valid) else $error("control word lost its beat");
   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_res_real == '0 && rsp_res_imag == '0)
      else $error("zero divisor with nonzero result");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> ##(W+2) rsp_valid) else $error("pipeline dropped a beat");

   logic unused_ok;
   assign unused_ok = ^{unused_r, unused_i, unused_ctl};

endmodule

// File: verif/complex_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb: self-checking bench for the complex ALU
// Drives directed corner beats, then random bursts of opcodes and operands.
// Every accepted beat is predicted in order and each rsp_valid beat is checked.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   localparam int W = 16;
   localparam int LATENCY = W + 4;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef logic signed [W-1:0] word_type;

   typedef struct {
      word_type res_real;
      word_type res_imag;
      logic     equal;
      logic     dz;
   } alu_result_type;

   class alu_scoreboard;
      alu_result_type pending[$];
      int errors;
      int checked;

      function word_type quot(longint n, longint d);
         quot = word_type'(n / d);
      endfunction

      function void note_beat(logic [3:0] op, word_type ar, word_type ai, word_type br,
                              word_type bi);
         alu_result_type r;
         word_type den, nr, ni;
         r.res_real = '0;
         r.res_imag = '0;
         r.dz = 1'b0;
         r.equal = (ar == br) && (ai == bi);
         case (op)
            OP_ADD: begin
               r.res_real = ar + br;
               r.res_imag = ai + bi;
            end
            OP_SUB: begin
               r.res_real = ar - br;
               r.res_imag = ai - bi;
            end
            OP_MUL: begin
               r.res_real = ar * br - ai * bi;
               r.res_imag = ar * bi + ai * br;
            end
            OP_DIV: begin
               den = br * br + bi * bi;
               if (den == 0) r.dz = 1'b1;
               else begin
                  nr = ar * br + ai * bi;
                  ni = ai * br - ar * bi;
                  r.res_real = quot(nr, den);
                  r.res_imag = quot(ni, den);
               end
            end
            OP_ADD_REAL: begin
               r.res_real = ar + br;
               r.res_imag = ai;
            end
            OP_SUB_REAL: begin
               r.res_real = ar - br;
               r.res_imag = ai;
            end
            OP_MUL_REAL: begin
               r.res_real = ar * br;
               r.res_imag = ai * br;
            end
            OP_DIV_REAL: begin
               if (br == 0) r.dz = 1'b1;
               else begin
                  r.res_real = quot(ar, br);
                  r.res_imag = quot(ai, br);
               end
            end
            OP_CONJ: begin
               r.res_real = ar;
               r.res_imag = -ai;
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function void check_beat(word_type rr, word_type ri, logic eq, logic dz);
         alu_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat: real %0d imag %0d", rr, ri);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (rr !== e.res_real) begin
            $error("res_real expected %0d actual %0d", e.res_real, rr);
            errors++;
         end
         if (ri !== e.res_imag) begin
            $error("res_imag expected %0d actual %0d", e.res_imag, ri);
            errors++;
         end
         if (eq !== e.equal) begin
            $error("operands_equal expected %0b actual %0b", e.equal, eq);
            errors++;
         end
         if (dz !== e.dz) begin
            $error("divide_by_zero expected %0b actual %0b", e.dz, dz);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [3:0] req_opcode = '0;
   word_type req_a_real = '0, req_a_imag = '0, req_b_real = '0, req_b_imag = '0;
   logic rsp_valid;
   word_type rsp_res_real, rsp_res_imag;
   logic rsp_operands_equal, rsp_divide_by_zero;

   alu_scoreboard sb = new();
   int idle_cycles = 0;
   int beats_sent = 0;

   complex_arithmetic_unit #(.DATA_WIDTH(W)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_a_real(req_a_real), .req_a_imag(req_a_imag),
      .req_b_real(req_b_real), .req_b_imag(req_b_imag),
      .rsp_valid(rsp_valid), .rsp_res_real(rsp_res_real), .rsp_res_imag(rsp_res_imag),
      .rsp_operands_equal(rsp_operands_equal), .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // sample at the edge, before the driver's nonblocking updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_beat(req_opcode, req_a_real, req_a_imag, req_b_real, req_b_imag);
            beats_sent++;
         end
         if (rsp_valid)
            sb.check_beat(rsp_res_real, rsp_res_imag, rsp_operands_equal, rsp_divide_by_zero);
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", sb.pending.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // holds the beat until accepted; start stays high if keep_going is set
   task automatic send_beat(logic [3:0] op, word_type ar, word_type ai, word_type br,
                            word_type bi, bit keep_going);
      req_opcode <= op;
      req_a_real <= ar;
      req_a_imag <= ai;
      req_b_real <= br;
      req_b_imag <= bi;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (!keep_going) start <= 1'b0;
   endtask

   task automatic pause_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic word_type rand_word();
      case ($urandom_range(0, 5))
         0: rand_word = 16'sh8000;
         1: rand_word = 16'sh7fff;
         2: rand_word = word_type'(int'($urandom_range(0, 6)) - 3);
         3: rand_word = word_type'(int'($urandom_range(0, 400)) - 200);
         default: rand_word = word_type'($urandom);
      endcase
   endfunction

   initial begin
      word_type mn, mx;
      logic [3:0] op;
      int burst, n;
      mn = 16'sh8000;
      mx = 16'sh7fff;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: extremes, every opcode, zero divisors, wrap cases
      for (int k = 0; k <= 8; k++)
         send_beat(k[3:0], mx, mn, mn, mx, 1);
      send_beat(OP_DIV, 16'sd5, -16'sd7, 16'sd0, 16'sd0, 1);
      send_beat(OP_DIV, 16'sd9, 16'sd3, 16'sd256, 16'sd0, 1);  // divisor wraps to zero
      send_beat(OP_DIV_REAL, mn, mn, 16'sd0, 16'sd3, 1);
      send_beat(OP_DIV_REAL, mn, mx, -16'sd1, 16'sd0, 1);      // quotient overflow
      send_beat(OP_DIV_REAL, -16'sd7, 16'sd7, 16'sd2, 16'sd0, 1);
      send_beat(OP_DIV, -16'sd100, 16'sd37, 16'sd3, -16'sd4, 1);
      send_beat(OP_CONJ, 16'sd12, mn, 16'sd12, mn, 1);          // equal, negate wraps
      send_beat(OP_MUL, mx, mx, mx, mx, 1);
      send_beat(4'd9, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1);
      send_beat(4'd15, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 1);
      send_beat(OP_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);

      // hold off until the pipeline has drained
      while (sb.pending.size() != 0) @(posedge clock);

      n = 0;
      while (n < 800) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst; k++) begin
            op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            if ($urandom_range(0, 7) == 0)
               send_beat(op, rand_word(), rand_word(), 16'sd0,
                         ($urandom_range(0, 1) ? 16'sd0 : rand_word()), 1);
            else if ($urandom_range(0, 9) == 0) begin
               mn = rand_word();
               mx = rand_word();
               send_beat(op, mn, mx, mn, mx, 1);
            end else
               send_beat(op, rand_word(), rand_word(), rand_word(), rand_word(), 1);
            n++;
         end
         if ($urandom_range(0, 3) != 0) pause_cycles($urandom_range(1, 2 * LATENCY));
         if (n > 400 && n < 440) begin
            start <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clock);
         end
      end
      start <= 1'b0;

      n = 0;
      while (sb.pending.size() != 0 && n < 100 * LATENCY) begin
         @(posedge clock);
         n++;
      end
      repeat (LATENCY + 4) @(posedge clock);

      $display("Sent %0d beats over all opcodes incl. zero divisors and wrap cases;", beats_sent);
      $display("checked %0d results, %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/core/cau_pkg.sv
rtl/core/cau_divider.sv
rtl/core/complex_arithmetic_unit.sv
verif/complex_arithmetic_unit_tb.sv
